[sv/aes128_key_expansion_macros.svh]
// ----------------------------------------------------------------------------
// AES-128 key expansion: assertion macros
// Clocked assertion wrappers used by the controller.
// ----------------------------------------------------------------------------
`ifndef AES128_KEY_EXPANSION_MACROS_SVH
`define AES128_KEY_EXPANSION_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define AESK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define AESK_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/aesk_pkg.sv]
// ----------------------------------------------------------------------------
// AES-128 key expansion package
// S-box table, round constants, round-key step function and shared types.
// ----------------------------------------------------------------------------
package aesk_pkg;

   localparam int unsigned RoundW = 4;
   localparam logic [RoundW-1:0] RoundFirst = 4'd0;
   localparam logic [RoundW-1:0] RoundLast  = 4'd10;

   localparam logic [0:255][7:0] Sbox = {
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   // Controller to datapath commands.
   typedef struct packed {
      logic              load;       // take the requested key as round 0
      logic              step;       // emit the held key and advance one round
      logic [RoundW-1:0] src_round;  // round of the key being emitted
   } cmd_type;

   // Rcon for the step from round r to round r+1.
   function automatic logic [31:0] rcon(input logic [RoundW-1:0] r);
      logic [31:0] c;
      c = 32'h0;
      case (r)
         4'd0:    c = 32'h01000000;
         4'd1:    c = 32'h02000000;
         4'd2:    c = 32'h04000000;
         4'd3:    c = 32'h08000000;
         4'd4:    c = 32'h10000000;
         4'd5:    c = 32'h20000000;
         4'd6:    c = 32'h40000000;
         4'd7:    c = 32'h80000000;
         4'd8:    c = 32'h1B000000;
         4'd9:    c = 32'h36000000;
         default: c = 32'h0;
      endcase
      return c;
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
   endfunction

   // One round of the AES-128 schedule: four new words from four old ones.
   function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                   input logic [31:0]  rc);
      logic [31:0] t;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
      t  = sub_word({k[23:0], k[31:24]}) ^ rc;
      w0 = k[127:96] ^ t;
      w1 = k[95:64]  ^ w0;
      w2 = k[63:32]  ^ w1;
      w3 = k[31:0]   ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

[sv/aesk_datapath.sv]
// ----------------------------------------------------------------------------
// AES-128 key expansion datapath
// Working key register, one-round expander and round-key output register.
// ----------------------------------------------------------------------------
module aesk_datapath
   import aesk_pkg::*;
(
   input  logic          clock,
   input  cmd_type       cmd,
   input  logic [63:0]   req_key_upper,
   input  logic [63:0]   req_key_lower,
   output logic [63:0]   rsp_round_key_upper,
   output logic [63:0]   rsp_round_key_lower
);

   logic [127:0] key_ff;
   logic [127:0] key_in;
   logic [127:0] src_key;
   logic [127:0] out_ff;
   logic [127:0] out_in;

   // round 0 comes straight from the request
   assign src_key = cmd.load ? {req_key_upper, req_key_lower} : key_ff;

   always_comb begin
      key_in = key_ff;
      out_in = out_ff;
      if (cmd.load || cmd.step) begin
         key_in = next_round_key(src_key, rcon(cmd.src_round));
         out_in = src_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      out_ff <= out_in;
   end

   assign rsp_round_key_upper = out_ff[127:64];
   assign rsp_round_key_lower = out_ff[63:0];

endmodule

[sv/aesk_ctrl.sv]
// ----------------------------------------------------------------------------
// AES-128 key expansion controller
// Round sequencer and output-valid tracking for the request/response channels.
// ----------------------------------------------------------------------------
`include "aes128_key_expansion_macros.svh"

module aesk_ctrl
   import aesk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [RoundW-1:0] rsp_round_index,
   output logic              rsp_final_round,
   output cmd_type           cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic [RoundW-1:0] round_ff;
   logic [RoundW-1:0] round_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [RoundW-1:0] out_round_ff;
   logic [RoundW-1:0] out_round_in;
   logic              out_last_ff;
   logic              out_last_in;

   logic              slot_free;
   logic              accept;
   logic              step;
   logic [RoundW-1:0] src_round;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign step      = (state_ff == ST_RUN) && slot_free;
   assign src_round = (state_ff == ST_IDLE) ? RoundFirst : round_ff;

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      out_valid_in = out_valid_ff;
      out_round_in = out_round_ff;
      out_last_in  = out_last_ff;
      if (accept) begin
         state_in = ST_RUN;
         round_in = RoundFirst + 4'd1;
      end else if (step) begin
         round_in = round_ff + 4'd1;
         if (round_ff == RoundLast) begin
            state_in = ST_IDLE;
         end
      end
      if (accept || step) begin
         out_valid_in = 1'b1;
         out_round_in = src_round;
         out_last_in  = (src_round == RoundLast);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= RoundFirst;
         out_valid_ff <= 1'b0;
         out_round_ff <= RoundFirst;
         out_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         out_valid_ff <= out_valid_in;
         out_round_ff <= out_round_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign cmd.load        = accept;
   assign cmd.step        = step;
   assign cmd.src_round   = src_round;
   assign rsp_valid       = out_valid_ff;
   assign rsp_round_index = out_round_ff;
   assign rsp_final_round = out_last_ff;

   `AESK_ASSERT(a_accept_gives_round0, clock, reset,
      accept |=> out_valid_ff && out_round_ff == RoundFirst,
      "accepted request did not present round 0")
   `AESK_ASSERT(a_rounds_follow, clock, reset,
      out_valid_ff && rsp_ready && !out_last_ff |=>
         out_valid_ff && out_round_ff == $past(out_round_ff) + 4'd1,
      "round keys not issued back to back in order")
   `AESK_ASSERT(a_run_round_range, clock, reset,
      state_ff == ST_RUN |-> round_ff != RoundFirst && round_ff <= RoundLast,
      "round counter out of range while running")
   `AESK_ASSERT(a_last_flag, clock, reset,
      out_valid_ff |-> out_last_ff == (out_round_ff == RoundLast),
      "final flag disagrees with round index")

endmodule

[sv/aes128_key_expansion.sv]
// ----------------------------------------------------------------------------
// AES-128 key expansion
// Expands one 128-bit cipher key into the eleven AES-128 round keys.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready): one cipher key as two 64-bit
//   halves, key byte 0 in bit 63 of req_key_upper.
//   Response channel (rsp_valid/rsp_ready): eleven round keys per request,
//   rounds 0 to 10 in order, with rsp_round_index naming each round and
//   rsp_final_round set on round 10.
//   Timing: round 0 appears the cycle after the request is taken; each later
//   round appears in the cycle after its predecessor is taken.
//   Throughput: with rsp_ready held high a new request is taken in the same
//   cycle as round 10 leaves, so keys stream without gaps. The single round
//   expander computes one schedule round (four words) per cycle while the
//   response channel is not stalled.
//   Stall: when rsp_ready is low the response register holds and the
//   expansion waits; nothing is dropped.
//   Reset: synchronous, active high; clears the sequencer and response
//   valid. The key and response key registers are not reset and keep key material.
// ----------------------------------------------------------------------------
module aes128_key_expansion
   import aesk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [63:0]       req_key_upper,
   input  logic [63:0]       req_key_lower,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [RoundW-1:0] rsp_round_index,
   output logic [63:0]       rsp_round_key_upper,
   output logic [63:0]       rsp_round_key_lower,
   output logic              rsp_final_round
);

   // load / step / rcon select from sequencer to datapath
   cmd_type cmd;

   aesk_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_round_index (rsp_round_index),
      .rsp_final_round (rsp_final_round),
      .cmd             (cmd)
   );

   // key register, expander and response key register
   aesk_datapath u_datapath (
      .clock               (clock),
      .cmd                 (cmd),
      .req_key_upper       (req_key_upper),
      .req_key_lower       (req_key_lower),
      .rsp_round_key_upper (rsp_round_key_upper),
      .rsp_round_key_lower (rsp_round_key_lower)
   );

endmodule
